[hw/rtl/chi_pkg.sv]
// Package for the cuckoo hash insert unit: table size, field widths,
// transaction structs, status codes and controller states. No dependencies.
`default_nettype none

package chi_pkg;

	// Table geometry
	localparam int TABLE_SIZE = 11;
	localparam int IDX_W      = $clog2(TABLE_SIZE);

	// Field widths
	localparam int KEY_W    = 31;
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 2;

	// Hash unit: multiply by the reciprocal of TABLE_SIZE, one operand per cycle
	localparam int HASH_CYCLES = 2;
	localparam int HCNT_W      = (HASH_CYCLES > 1) ? $clog2(HASH_CYCLES) : 1;
	localparam int RECIP_W     = 32;
	localparam int RECIP_SHIFT = KEY_W + IDX_W;
	localparam int PROD_W      = KEY_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_MUL =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + TABLE_SIZE - 1) / TABLE_SIZE);

	localparam logic [COUNT_W-1:0] MAX_DISP_RESET = COUNT_W'(16);

	// Command codes
	localparam logic CMD_CLEAR  = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_CLEARED  = 2'd0,
		ST_INSERTED = 2'd1,
		ST_PRESENT  = 2'd2,
		ST_CYCLE    = 2'd3
	} status_t;

	typedef struct packed {
		logic             cmd;
		logic [KEY_W-1:0] key;
	} in_t;

	typedef struct packed {
		status_t            status;
		logic [KEY_W-1:0]   dropped_key;
		logic [COUNT_W-1:0] displacements;
	} out_t;

	// Table entry: key plus its slot in the other table
	typedef struct packed {
		logic [IDX_W-1:0] alt;
		logic [KEY_W-1:0] key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

[hw/rtl/chi_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module chi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/cuckoo_hash_insert_unit.sv]
// Two-table cuckoo hash insert unit: controller, hash unit, valid flags.
// Depends on chi_pkg and chi_ram (one instance per table).
//
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_stall    in_data  (chi_pkg::in_t)
// out       out  out_valid / out_stall  out_data (chi_pkg::out_t)
// cfg       in   cfg_we                 cfg_wdata (max_displacements)
//
// Clear: accept, then post the result.
// Insert: accept, hash the new key, then for each walk step read the tables,
// then check and write back; finally post the result. Posting waits while
// the output register is full and stalled.
// Reset empties both tables through per-entry valid flops; no clearing pass.
// A waiting result sits in the output register; the next transaction is
// taken meanwhile, and its result is held until the output register frees.
`default_nettype none

module cuckoo_hash_insert_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire chi_pkg::in_t                  in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output chi_pkg::out_t                      out_data,
	input  wire logic                          cfg_we,
	input  wire logic [chi_pkg::COUNT_W-1:0]   cfg_wdata
);

	import chi_pkg::*;

	state_t state_q, state_d;

	logic [COUNT_W-1:0]    max_q;
	logic [KEY_W-1:0]      hand_q;
	logic [IDX_W-1:0]      idx0_q, idx1_q;
	logic                  table_q;
	logic [COUNT_W-1:0]    count_q;
	logic [KEY_W-1:0]      quo_q;
	logic [HCNT_W-1:0]     hcnt_q;
	logic [TABLE_SIZE-1:0] valid0_q, valid1_q;
	out_t                  res_q;
	out_t                  out_data_q;
	logic                  out_valid_q;

	logic       in_acc;
	logic       hash_last;
	logic       limit_hit;
	logic       post;
	logic [KEY_W-1:0]  div_op;
	logic [PROD_W-1:0] div_prod;
	logic [KEY_W-1:0]  div_quo;
	logic [KEY_W-1:0]  div_rem;

	entry_t     rd0, rd1;
	logic       ram_re;
	logic       we0, we1;
	entry_t     wr0, wr1;
	logic       hit0, hit1, found;
	logic       tgt_valid;
	entry_t     tgt;

	assign in_acc    = in_valid && !in_stall;
	assign hash_last = (hcnt_q == HCNT_W'(HASH_CYCLES - 1));
	assign limit_hit = (count_q == max_q);
	assign post      = !out_valid_q || !out_stall;

	// Table memories
	chi_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram0 (
		.clk   (clk),
		.we    (we0),
		.waddr (idx0_q),
		.wdata (wr0),
		.re    (ram_re),
		.raddr (idx0_q),
		.rdata (rd0)
	);

	chi_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram1 (
		.clk   (clk),
		.we    (we1),
		.waddr (idx1_q),
		.wdata (wr1),
		.re    (ram_re),
		.raddr (idx1_q),
		.rdata (rd1)
	);

	// Hash: reciprocal multiply gives the quotient, remainder by subtraction;
	// the first step divides the key, the second divides its quotient
	always_comb begin
		div_op   = hash_last ? quo_q : hand_q;
		div_prod = PROD_W'(div_op) * PROD_W'(RECIP_MUL);
		div_quo  = KEY_W'(div_prod[PROD_W-1:RECIP_SHIFT]);
		div_rem  = div_op - div_quo * KEY_W'(TABLE_SIZE);
	end

	// Compare the key in hand against both candidate slots
	always_comb begin
		hit0      = valid0_q[idx0_q] && (rd0.key == hand_q);
		hit1      = valid1_q[idx1_q] && (rd1.key == hand_q);
		found     = hit0 || hit1;
		tgt_valid = table_q ? valid1_q[idx1_q] : valid0_q[idx0_q];
		tgt       = table_q ? rd1 : rd0;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = (in_data.cmd == CMD_CLEAR) ? S_DONE : S_HASH;
				end
			end
			S_HASH: begin
				if (hash_last) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = limit_hit ? S_DONE : S_CHECK;
			end
			S_CHECK: begin
				state_d = (found || !tgt_valid) ? S_DONE : S_READ;
			end
			S_DONE: begin
				if (post) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Controller outputs
	always_comb begin
		in_stall = 1'b1;
		ram_re   = 1'b0;
		we0      = 1'b0;
		we1      = 1'b0;
		wr0      = '{alt: idx1_q, key: hand_q};
		wr1      = '{alt: idx0_q, key: hand_q};
		case (state_q)
			S_IDLE:  in_stall = 1'b0;
			S_READ:  ram_re   = !limit_hit;
			S_CHECK: begin
				we0 = !found && !table_q;
				we1 = !found && table_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_DISP_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// Valid flags: clear on command, set on placement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid0_q <= '0;
			valid1_q <= '0;
		end else if (state_q == S_IDLE && in_acc && in_data.cmd == CMD_CLEAR) begin
			valid0_q <= '0;
			valid1_q <= '0;
		end else begin
			if (we0) begin
				valid0_q[idx0_q] <= 1'b1;
			end
			if (we1) begin
				valid1_q[idx1_q] <= 1'b1;
			end
		end
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				hand_q  <= in_data.key;
				idx0_q  <= '0;
				idx1_q  <= '0;
				table_q <= 1'b0;
				count_q <= '0;
				res_q   <= '{status: ST_CLEARED, dropped_key: '0, displacements: '0};
			end
			S_HASH: begin
				if (hash_last) begin
					idx1_q <= div_rem[IDX_W-1:0];
				end else begin
					idx0_q <= div_rem[IDX_W-1:0];
					quo_q  <= div_quo;
				end
			end
			S_READ: begin
				res_q <= '{status: ST_CYCLE, dropped_key: hand_q, displacements: count_q};
			end
			S_CHECK: begin
				if (found) begin
					res_q <= '{status: (count_q == '0) ? ST_PRESENT : ST_INSERTED,
						dropped_key: '0, displacements: count_q};
				end else if (!tgt_valid) begin
					res_q <= '{status: ST_INSERTED, dropped_key: '0, displacements: count_q};
				end else begin
					// Take over the slot, carry the evicted key to the other table
					hand_q  <= tgt.key;
					table_q <= !table_q;
					count_q <= count_q + COUNT_W'(1);
					if (table_q) begin
						idx0_q <= tgt.alt;
					end else begin
						idx1_q <= tgt.alt;
					end
				end
			end
			default: ;
		endcase
	end

	// Hash step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
		end else if (state_q == S_HASH) begin
			hcnt_q <= hash_last ? '0 : hcnt_q + HCNT_W'(1);
		end
	end

	// Output register: load when free or draining, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && post) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && post) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
